>>> sv/binary_descriptor_nn_matcher_defines.svh
`ifndef BINARY_DESCRIPTOR_NN_MATCHER_DEFINES_SVH
`define BINARY_DESCRIPTOR_NN_MATCHER_DEFINES_SVH

// assertion helpers, empty in synthesis
`ifndef SYNTHESIS
`define BDNN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BDNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDNN_ASSERT(lbl, prop, msg)
`define BDNN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/bdnn_pkg.sv
package bdnn_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DESC_BITS   = 256;

  localparam int WORD_BITS  = 64;
  localparam int IN_WORDS   = 4;
  localparam int IN_BITS    = IN_WORDS * WORD_BITS;
  localparam int DESC_WORDS = (DESC_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W      = DESC_WORDS * WORD_BITS;
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int DIST_W     = $clog2(DESC_BITS + 1);
  localparam int PCNT_W     = $clog2(WORD_BITS + 1);
  localparam int CAP_W      = 9;
  localparam int RATIO_W    = 4;
  localparam int PROD_W     = CAP_W + RATIO_W;
  localparam int OUT_IDX_W  = 10;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [IN_BITS-1:0] DESC_MASK = {IN_BITS{1'b1}} >> (IN_BITS - DESC_BITS);

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TENTHS = 2'd2;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 9'd128;
  localparam logic [CAP_W-1:0]   MAX_RESET   = 9'd80;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] hd;
  } chain_t;

  typedef struct packed {
    logic             valid;
    logic             match;
    logic [IDX_W-1:0] idx;
    logic [CAP_W-1:0] best;
    logic [CAP_W-1:0] second;
  } result_t;

  function automatic logic [PCNT_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [PCNT_W-1:0] acc [WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      acc[i] = PCNT_W'(w[i]);
    end
    for (int s = 1; s < WORD_BITS; s = s * 2) begin
      for (int i = 0; i + s < WORD_BITS; i = i + 2 * s) begin
        acc[i] = acc[i] + acc[i+s];
      end
    end
    return acc[0];
  endfunction

endpackage

>>> sv/bdnn_cell.sv
module bdnn_cell
  import bdnn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [WORD_BITS-1:0] query_i,
  input  chain_t               chain_i,
  input  logic [ROW_W-1:0]     row_i,
  output chain_t               chain_o,
  output logic [ROW_W-1:0]     row_o
);

  logic [WORD_BITS-1:0] q_word_q;
  logic                 valid_q, last_q;
  logic [IDX_W-1:0]     idx_q;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic [ROW_W-1:0]     row_q, row_d;

  // add this word's distance and hand the rest of the row on
  assign dist_d = chain_i.hd + DIST_W'(popcount(q_word_q ^ row_i[WORD_BITS-1:0]));
  assign row_d  = row_i >> WORD_BITS;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_word_q <= query_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= chain_i.valid;
      last_q  <= chain_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= chain_i.idx;
    dist_q <= dist_d;
    row_q  <= row_d;
  end

  assign chain_o.valid = valid_q;
  assign chain_o.last  = last_q;
  assign chain_o.idx   = idx_q;
  assign chain_o.hd    = dist_q;
  assign row_o         = row_q;

endmodule

>>> sv/bdnn_tracker.sv
module bdnn_tracker
  import bdnn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               init_i,
  input  logic [CAP_W-1:0]   cap_i,
  input  logic [CAP_W-1:0]   max_i,
  input  logic [RATIO_W-1:0] ratio_i,
  input  chain_t             chain_i,
  output result_t            res_o
);

  logic [CAP_W-1:0]  best_q, best_d, second_q, second_d, cur_hd;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  logic [PROD_W-1:0] lhs, rhs;
  logic              match_d;
  logic              res_valid_q;
  logic              res_match_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [CAP_W-1:0]  res_best_q, res_second_q;

  assign cur_hd = CAP_W'(chain_i.hd);

  always_comb begin
    best_d   = best_q;
    second_d = second_q;
    idx_d    = idx_q;
    found_d  = found_q;
    priority if (init_i) begin
      best_d   = cap_i;
      second_d = cap_i;
      idx_d    = '0;
      found_d  = 1'b0;
    end else if (chain_i.valid && cur_hd < best_q) begin
      second_d = best_q;
      best_d   = cur_hd;
      idx_d    = chain_i.idx;
      found_d  = 1'b1;
    end else if (chain_i.valid && cur_hd < second_q) begin
      second_d = cur_hd;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    second_q <= second_d;
    idx_q    <= idx_d;
    found_q  <= found_d;
  end

  // ratio test: best times ten against ratio times second
  assign lhs     = (PROD_W'(best_q) << 3) + (PROD_W'(best_q) << 1);
  assign rhs     = PROD_W'(ratio_i) * PROD_W'(second_q);
  assign match_d = found_q && (best_q < max_i) && (lhs < rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= chain_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_i.last) begin
      res_match_q  <= match_d;
      res_idx_q    <= idx_q;
      res_best_q   <= best_q;
      res_second_q <= second_q;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.match  = res_match_q;
  assign res_o.idx    = res_idx_q;
  assign res_o.best   = res_best_q;
  assign res_o.second = res_second_q;

endmodule

>>> sv/binary_descriptor_nn_matcher.sv
// result: strobes after a query's entries pass the read register, cells and tracker
// busy: held until a query's last entry leaves the chain, paced by the reference
//   memory walk of one entry per cycle plus the four-cell distance chain
// load and clear: no result; the result strobe cannot be stalled
// reset: table empty, registers at 128 / 80 / 7, no clearing pass
`include "binary_descriptor_nn_matcher_defines.svh"

module binary_descriptor_nn_matcher
  import bdnn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [WORD_BITS-1:0]  desc_word0_i,
  input  logic [WORD_BITS-1:0]  desc_word1_i,
  input  logic [WORD_BITS-1:0]  desc_word2_i,
  input  logic [WORD_BITS-1:0]  desc_word3_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  match_found_o,
  output logic [OUT_IDX_W-1:0]  best_index_o,
  output logic [CAP_W-1:0]      best_distance_o,
  output logic [CAP_W-1:0]      second_distance_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   entry_cnt_q, scan_cnt_q;
  logic [CAP_W-1:0]   cap_q, max_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [IN_BITS-1:0] desc_full;
  logic [ROW_W-1:0]   desc_row;
  logic               accept, query_acc, load_acc, clear_acc, table_full;
  logic               scan_done, issue_valid, issue_last;
  logic [ROW_W-1:0]   mem_q [TABLE_DEPTH];
  logic [ROW_W-1:0]   rd_row_q;
  chain_t             src_q;
  chain_t             chain_w [DESC_WORDS+1];
  logic [ROW_W-1:0]   row_w [DESC_WORDS+1];
  result_t            res;

  assign desc_full = {desc_word3_i, desc_word2_i, desc_word1_i, desc_word0_i} & DESC_MASK;
  assign desc_row  = desc_full[ROW_W-1:0];

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign table_full = (entry_cnt_q == CNT_W'(TABLE_DEPTH));
  assign query_acc  = accept && (cmd_i == CMD_QUERY);
  assign load_acc   = accept && (cmd_i == CMD_LOAD) && !table_full;
  assign clear_acc  = accept && (cmd_i == CMD_CLEAR);
  assign scan_done  = (scan_cnt_q == entry_cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (chain_w[DESC_WORDS].last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue_valid = 1'b0;
    issue_last  = 1'b0;
    unique case (state_q)
      ST_SCAN: begin
        issue_valid = !scan_done;
        issue_last  = scan_done;
      end
      default: begin
        issue_valid = 1'b0;
        issue_last  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      entry_cnt_q <= '0;
      scan_cnt_q  <= '0;
      src_q.valid <= 1'b0;
      src_q.last  <= 1'b0;
      src_q.idx   <= '0;
      src_q.hd    <= '0;
    end else begin
      state_q     <= state_d;
      src_q.valid <= issue_valid;
      src_q.last  <= issue_last;
      src_q.idx   <= scan_cnt_q[IDX_W-1:0];
      src_q.hd    <= '0;
      if (clear_acc) begin
        entry_cnt_q <= '0;
      end else if (load_acc) begin
        entry_cnt_q <= entry_cnt_q + 1'b1;
      end
      if (query_acc) begin
        scan_cnt_q <= '0;
      end else if (issue_valid) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mem_q[entry_cnt_q[IDX_W-1:0]] <= desc_row;
    end
    rd_row_q <= mem_q[scan_cnt_q[IDX_W-1:0]];
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      max_q   <= MAX_RESET;
      ratio_q <= RATIO_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DISTANCE_CAP: cap_q   <= cfg_data_i;
        CFG_MAX_DISTANCE: max_q   <= cfg_data_i;
        CFG_RATIO_TENTHS: ratio_q <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign chain_w[0] = src_q;
  assign row_w[0]   = rd_row_q;

  for (genvar k = 0; k < DESC_WORDS; k++) begin : g_cell
    bdnn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (query_acc),
      .query_i (desc_row[k*WORD_BITS +: WORD_BITS]),
      .chain_i (chain_w[k]),
      .row_i   (row_w[k]),
      .chain_o (chain_w[k+1]),
      .row_o   (row_w[k+1])
    );
  end

  bdnn_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (query_acc),
    .cap_i   (cap_q),
    .max_i   (max_q),
    .ratio_i (ratio_q),
    .chain_i (chain_w[DESC_WORDS]),
    .res_o   (res)
  );

  assign done_o            = res.valid;
  assign match_found_o     = res.match;
  assign best_index_o      = OUT_IDX_W'(res.idx);
  assign best_distance_o   = res.best;
  assign second_distance_o = res.second;

  `BDNN_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result strobe with no query")
  `BDNN_ASSERT_NEXT(a_query_busy, query_acc, busy, "query transfer did not raise busy")
  `BDNN_ASSERT_NEXT(a_full_load, accept && cmd_i == CMD_LOAD && table_full, table_full, "full load")
  `BDNN_ASSERT(a_scan_bound, state_q == ST_SCAN |-> scan_cnt_q <= entry_cnt_q, "scan overrun")
  `BDNN_ASSERT(a_dist_order, done_o |-> best_distance_o <= second_distance_o, "best above second")

endmodule
